// ===== rtl/ilcd_pkg.sv =====
// shared types and constants for the i2c lcd nibble sender
// no dependencies
package ilcd_pkg;

    localparam int unsigned CfgAddrW = 4;
    localparam int unsigned CfgDataW = 32;

    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_BACKLIGHT_ON   = 2'd1;
    localparam logic [1:0] REG_GAP_SHORT      = 2'd2;
    localparam logic [1:0] REG_GAP_LONG       = 2'd3;

    localparam logic [6:0] DEV_ADDR_RESET  = 7'h27;
    localparam logic [9:0] GAP_SHORT_RESET = 10'd16;
    localparam logic [9:0] GAP_LONG_RESET  = 10'd160;

    localparam logic [7:0] EN_BIT  = 8'h04;
    localparam logic [7:0] BL_BIT  = 8'h08;
    localparam logic [7:0] HI_MASK = 8'hf0;

    localparam logic [2:0] LAST_TRANSACTION = 3'd5;
    localparam logic [3:0] BITS_PER_BYTE    = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE, PH_PRE_GAP, PH_START_A, PH_START_B, PH_BYTE_PRE, PH_BIT_SET,
        PH_BIT_HI, PH_BIT_LO, PH_ACK_REL, PH_ACK_HI, PH_ACK_LO, PH_STOP_A,
        PH_STOP_B, PH_STOP_C, PH_MID_GAP, PH_POST_GAP
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       register_select;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic accepted;
        logic busy_res;
        logic scl;
        logic sda;
        logic nack_seen;
        logic done_res;
    } t_out_item;

    typedef struct packed {
        logic [6:0] device_address;
        logic       backlight_on;
        logic [9:0] gap_short;
        logic [9:0] gap_long;
    } t_cfg;

endpackage

// ===== rtl/ilcd_regs.sv =====
// apb configuration registers: device address, backlight, gap lengths
// depends on ilcd_pkg
module ilcd_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ilcd_pkg::CfgAddrW-1:0]  paddr,
    input  logic [ilcd_pkg::CfgDataW-1:0]  pwdata,
    output logic [ilcd_pkg::CfgDataW-1:0]  prdata,
    output logic                           pready,
    output ilcd_pkg::t_cfg                 o_cfg
);
    import ilcd_pkg::*;

    t_cfg r_cfg;
    logic w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[CfgAddrW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= DEV_ADDR_RESET;
            r_cfg.backlight_on   <= 1'b1;
            r_cfg.gap_short      <= GAP_SHORT_RESET;
            r_cfg.gap_long       <= GAP_LONG_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DEVICE_ADDRESS: r_cfg.device_address <= pwdata[6:0];
                REG_BACKLIGHT_ON:   r_cfg.backlight_on   <= pwdata[0];
                REG_GAP_SHORT:      r_cfg.gap_short      <= pwdata[9:0];
                REG_GAP_LONG:       r_cfg.gap_long       <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DEVICE_ADDRESS: prdata = {25'd0, r_cfg.device_address};
            REG_BACKLIGHT_ON:   prdata = {31'd0, r_cfg.backlight_on};
            REG_GAP_SHORT:      prdata = {22'd0, r_cfg.gap_short};
            REG_GAP_LONG:       prdata = {22'd0, r_cfg.gap_long};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/ilcd_seq.sv =====
// bit-level i2c sequencer state and one-step update per beat
// depends on ilcd_pkg
module ilcd_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ilcd_pkg::t_in_item  i_item,
    input  ilcd_pkg::t_cfg      i_cfg,
    output ilcd_pkg::t_out_item o_res
);
    import ilcd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_high, n_high;
    logic [7:0] r_low, n_low;
    logic [2:0] r_tidx, n_tidx;
    logic       r_bidx, n_bidx;
    logic [7:0] r_shift, n_shift;
    logic [3:0] r_bit, n_bit;
    logic [9:0] r_gap, n_gap;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_nack, n_nack;
    logic       w_acc, w_done;
    logic [7:0] w_frame;
    logic [7:0] w_base;
    logic [3:0] w_bit_inc;

    always_comb begin
        w_frame = (r_tidx < 3'd3) ? r_high : r_low;
        if (r_tidx == 3'd1 || r_tidx == 3'd4 || r_tidx == 3'd7) begin
            w_frame = w_frame | EN_BIT;
        end
    end

    assign w_base    = {7'd0, i_item.register_select} | (i_cfg.backlight_on ? BL_BIT : 8'd0);
    assign w_bit_inc = r_bit + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_high  <= '0;
            r_low   <= '0;
            r_tidx  <= '0;
            r_bidx  <= 1'b0;
            r_shift <= '0;
            r_bit   <= '0;
            r_gap   <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_nack  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_low   <= n_low;
            r_tidx  <= n_tidx;
            r_bidx  <= n_bidx;
            r_shift <= n_shift;
            r_bit   <= n_bit;
            r_gap   <= n_gap;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_nack  <= n_nack;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_high  = r_high;
        n_low   = r_low;
        n_tidx  = r_tidx;
        n_bidx  = r_bidx;
        n_shift = r_shift;
        n_bit   = r_bit;
        n_gap   = r_gap;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_nack  = r_nack;
        w_acc   = 1'b0;
        w_done  = 1'b0;
        if (i_fire) begin
            if (i_item.kind) begin
                if (r_phase == PH_IDLE) begin
                    n_high  = w_base | (i_item.data_byte & HI_MASK);
                    n_low   = w_base | ({i_item.data_byte[3:0], 4'd0});
                    n_tidx  = '0;
                    n_bidx  = 1'b0;
                    n_phase = PH_PRE_GAP;
                    n_gap   = i_cfg.gap_long;
                    w_acc   = 1'b1;
                end
            end else begin
                if (r_phase == PH_ACK_LO) begin
                    n_nack = i_item.sda_in;
                end
                unique case (r_phase)
                    PH_PRE_GAP, PH_MID_GAP: begin
                        if (r_gap != 10'd0) begin
                            n_gap = r_gap - 10'd1;
                        end else begin
                            if (r_phase == PH_MID_GAP) begin
                                n_tidx = r_tidx + 3'd1;
                            end
                            n_sda   = 1'b0;
                            n_phase = PH_START_B;
                        end
                    end
                    PH_POST_GAP: begin
                        if (r_gap != 10'd0) begin
                            n_gap = r_gap - 10'd1;
                        end else begin
                            n_phase = PH_IDLE;
                            w_done  = 1'b1;
                        end
                    end
                    PH_START_A: begin
                        n_sda   = 1'b0;
                        n_phase = PH_START_B;
                    end
                    PH_START_B: begin
                        n_scl   = 1'b0;
                        n_bidx  = 1'b0;
                        n_phase = PH_BYTE_PRE;
                    end
                    PH_BYTE_PRE: begin
                        n_shift = r_bidx ? w_frame : {i_cfg.device_address, 1'b0};
                        n_bit   = '0;
                        n_phase = PH_BIT_SET;
                    end
                    PH_BIT_SET: begin
                        n_sda   = r_shift[7];
                        n_phase = PH_BIT_HI;
                    end
                    PH_BIT_HI: begin
                        n_scl   = 1'b1;
                        n_phase = PH_BIT_LO;
                    end
                    PH_BIT_LO: begin
                        n_scl   = 1'b0;
                        n_shift = {r_shift[6:0], 1'b0};
                        n_bit   = w_bit_inc;
                        n_phase = (w_bit_inc >= BITS_PER_BYTE) ? PH_ACK_REL : PH_BIT_SET;
                    end
                    PH_ACK_REL: begin
                        n_sda   = 1'b1;
                        n_phase = PH_ACK_HI;
                    end
                    PH_ACK_HI: begin
                        n_scl   = 1'b1;
                        n_phase = PH_ACK_LO;
                    end
                    PH_ACK_LO: begin
                        n_scl = 1'b0;
                        if (!r_bidx) begin
                            n_bidx  = 1'b1;
                            n_phase = PH_BYTE_PRE;
                        end else begin
                            n_phase = PH_STOP_A;
                        end
                    end
                    PH_STOP_A: begin
                        n_sda   = 1'b0;
                        n_phase = PH_STOP_B;
                    end
                    PH_STOP_B: begin
                        n_scl   = 1'b1;
                        n_phase = PH_STOP_C;
                    end
                    PH_STOP_C: begin
                        n_sda = 1'b1;
                        if (r_tidx >= LAST_TRANSACTION) begin
                            n_phase = PH_POST_GAP;
                            n_gap   = i_cfg.gap_long;
                        end else begin
                            n_phase = PH_MID_GAP;
                            n_gap   = i_cfg.gap_short;
                        end
                    end
                    PH_IDLE: ;
                    default: ;
                endcase
            end
        end
    end

    assign o_res.accepted  = w_acc;
    assign o_res.busy_res  = (n_phase != PH_IDLE);
    assign o_res.scl       = n_scl;
    assign o_res.sda       = n_sda;
    assign o_res.nack_seen = n_nack;
    assign o_res.done_res  = w_done;

    a_done_from_post_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done_res |-> (r_phase == PH_POST_GAP && r_gap == 10'd0))
        else $error("done outside the final gap");

    a_bit_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= BITS_PER_BYTE)
        else $error("bit index past one byte");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.accepted) |=> (r_phase == PH_PRE_GAP && r_tidx == 3'd0))
        else $error("accepted byte did not start the sequence");

    a_tidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tidx <= LAST_TRANSACTION)
        else $error("transaction index past the last transaction");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_scl && r_sda))
        else $error("bus lines held while idle");

endmodule

// ===== rtl/i2c_lcd_nibble_sender.sv =====
// top level of the i2c lcd nibble sender: input register, sequencer, result register
// depends on ilcd_pkg, ilcd_regs, ilcd_seq
//
// usage
// input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per item:
// a tick (kind 0) advances the i2c bit sequencer by one delay step, a submit
// (kind 1) hands over a byte and register select for the lcd in 4-bit mode
// output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
// result beat per input beat, in order, with the line levels after that item
// an accepted item goes from the input register through one step of the sequencer
// into the result register
// throughput: one item per cycle while the receiver is not stalled; the sequencer
// state update is a single step of short logic so back-to-back beats are taken
// a stalled receiver holds the result register; the input register keeps
// filling and o_in_ready drops only while both registers are full and stalled
// reset (synchronous, active low) empties both registers, releases scl and sda,
// clears the sequencer to idle and loads the register defaults (address 0x27,
// backlight on, short gap 16, long gap 160); the user must write configuration
// over the apb port only while the block is idle; the block does not enforce it
module i2c_lcd_nibble_sender (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ilcd_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ilcd_pkg::t_out_item            o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ilcd_pkg::CfgAddrW-1:0]  paddr,
    input  logic [ilcd_pkg::CfgDataW-1:0]  pwdata,
    output logic [ilcd_pkg::CfgDataW-1:0]  prdata,
    output logic                           pready
);
    import ilcd_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      w_adv;
    t_cfg      w_cfg;
    t_out_item w_res;

    ilcd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv      = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | ~r_out_valid | i_out_ready;

    ilcd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_item  (r_in_data),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (~r_out_valid | i_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
